// File: hdl/segtree_pkg.sv
package segtree_pkg;

   // Tree geometry. The leaf count is already a power of two, so the tree size equals it.
   localparam int LEAVES    = 1024;
   localparam int LEAF_W    = $clog2(LEAVES);
   localparam int TREE_SIZE = 1 << LEAF_W;
   localparam int NODE_AW   = LEAF_W + 1;
   localparam int TIDX_W    = NODE_AW + 1;
   localparam int VAL_W     = 32;
   localparam int NODE_W    = VAL_W + LEAF_W;
   localparam int KIND_W    = 2;

   localparam logic [KIND_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] REQ_QUERY = 2'd1;
   localparam logic [KIND_W-1:0] REQ_CLEAR = 2'd2;

   typedef struct packed {
      logic load_write;
      logic load_query;
      logic clr_step;
      logic wr_leaf;
      logic wr_up;
      logic q_step;
      logic q_acc;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic up_last;
      logic q_more;
   } stat_type;

endpackage

// File: hdl/segtree_ctrl.sv
module segtree_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [segtree_pkg::KIND_W-1:0]    req_type,
   input  segtree_pkg::stat_type             stat,
   output segtree_pkg::cmd_type              cmd,
   output logic                              busy,
   output logic                              rsp_valid
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_WLEAF = 3'd2;
   localparam logic [2:0] ST_WUP   = 3'd3;
   localparam logic [2:0] ST_QRUN  = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign busy      = (state_ff != ST_IDLE) && (state_ff != ST_RESP);
   assign rsp_valid = (state_ff == ST_RESP);
   assign accept    = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff) inside
         ST_IDLE, ST_RESP: begin
            state_in = ST_IDLE;
            if (accept) begin
               unique case (req_type)
                  segtree_pkg::REQ_WRITE: begin
                     cmd.load_write = 1'b1;
                     state_in       = ST_WLEAF;
                  end
                  segtree_pkg::REQ_QUERY: begin
                     cmd.load_query = 1'b1;
                     state_in       = ST_QRUN;
                  end
                  segtree_pkg::REQ_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_WLEAF: begin
            cmd.wr_leaf = 1'b1;
            state_in    = ST_WUP;
         end
         ST_WUP: begin
            cmd.wr_up = 1'b1;
            if (stat.up_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRUN: begin
            // The reads of the previous level are summed here, so the last cycle
            // with no further level to issue also drains the final reads.
            cmd.q_acc = 1'b1;
            if (stat.q_more) begin
               cmd.q_step = 1'b1;
            end else begin
               state_in = ST_RESP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/segtree_dp.sv
module segtree_dp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  segtree_pkg::cmd_type                     cmd,
   input  logic [segtree_pkg::LEAF_W-1:0]           req_leaf_index,
   input  logic signed [segtree_pkg::VAL_W-1:0]     req_leaf_value,
   input  logic [segtree_pkg::NODE_AW-1:0]          req_range_left,
   input  logic [segtree_pkg::NODE_AW-1:0]          req_range_right,
   output segtree_pkg::stat_type                    stat,
   output logic [segtree_pkg::NODE_W-1:0]           sum_out
);

   localparam int NODE_W  = segtree_pkg::NODE_W;
   localparam int NODE_AW = segtree_pkg::NODE_AW;
   localparam int TIDX_W  = segtree_pkg::TIDX_W;
   localparam int VAL_W   = segtree_pkg::VAL_W;

   localparam logic [NODE_AW-1:0] TREE_SIZE_N = NODE_AW'(segtree_pkg::TREE_SIZE);
   localparam logic [TIDX_W-1:0]  TREE_SIZE_T = TIDX_W'(segtree_pkg::TREE_SIZE);

   // Heap layout: the root is node 1 and leaf i is node TREE_SIZE + i; node 0 is unused.
   logic [NODE_W-1:0]  node_mem [0:(1 << NODE_AW)-1];

   logic [NODE_AW-1:0] idx_ff, idx_in;
   logic [NODE_AW-1:0] sweep_ff, sweep_in;
   logic [TIDX_W-1:0]  left_ff, left_in;
   logic [TIDX_W-1:0]  right_ff, right_in;
   logic [NODE_W-1:0]  acc_ff, acc_in;
   logic [NODE_W-1:0]  rda_ff, rdb_ff;
   logic               take_a_ff, take_a_in;
   logic               take_b_ff, take_b_in;

   logic [NODE_AW-1:0] raddr_a, raddr_b;
   logic               we;
   logic [NODE_AW-1:0] waddr;
   logic [NODE_W-1:0]  wdata;

   logic [NODE_AW-1:0] parent;
   logic [NODE_W-1:0]  up_sum;
   logic [NODE_W-1:0]  term_a, term_b;
   logic [TIDX_W-1:0]  left_inc, right_dec;
   logic [NODE_AW-1:0] sat_left, sat_right;

   assign parent    = {1'b0, idx_ff[NODE_AW-1:1]};
   assign up_sum    = acc_ff + rda_ff;
   assign term_a    = take_a_ff ? rda_ff : '0;
   assign term_b    = take_b_ff ? rdb_ff : '0;
   assign left_inc  = left_ff + TIDX_W'(left_ff[0]);
   assign right_dec = right_ff - TIDX_W'(1);
   assign sat_left  = (req_range_left > TREE_SIZE_N) ? TREE_SIZE_N : req_range_left;
   assign sat_right = (req_range_right > TREE_SIZE_N) ? TREE_SIZE_N : req_range_right;

   assign stat.sweep_last = &sweep_ff;
   assign stat.up_last    = (idx_ff[NODE_AW-1:1] == (NODE_AW-1)'(1));
   assign stat.q_more     = (left_ff < right_ff);
   assign sum_out         = acc_ff;

   always_comb begin
      idx_in    = idx_ff;
      sweep_in  = sweep_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      acc_in    = acc_ff;
      take_a_in = 1'b0;
      take_b_in = 1'b0;
      raddr_a   = idx_ff ^ NODE_AW'(1);
      raddr_b   = right_dec[NODE_AW-1:0];
      we        = 1'b0;
      waddr     = idx_ff;
      wdata     = acc_ff;

      if (cmd.load_write) begin
         idx_in = {1'b1, req_leaf_index};
         acc_in = {{(NODE_W-VAL_W){req_leaf_value[VAL_W-1]}}, req_leaf_value};
      end
      if (cmd.load_query) begin
         left_in  = TIDX_W'(sat_left) + TREE_SIZE_T;
         right_in = TIDX_W'(sat_right) + TREE_SIZE_T;
         acc_in   = '0;
      end
      if (cmd.clr_step) begin
         we       = 1'b1;
         waddr    = sweep_ff;
         wdata    = '0;
         sweep_in = sweep_ff + NODE_AW'(1);
      end
      if (cmd.wr_leaf) begin
         we = 1'b1;
      end
      if (cmd.wr_up) begin
         // The sibling read in the previous cycle joins the running sum to form the parent.
         we      = 1'b1;
         waddr   = parent;
         wdata   = up_sum;
         acc_in  = up_sum;
         idx_in  = parent;
         raddr_a = parent ^ NODE_AW'(1);
      end
      if (cmd.q_step) begin
         raddr_a   = left_ff[NODE_AW-1:0];
         take_a_in = left_ff[0];
         take_b_in = right_ff[0];
         left_in   = {1'b0, left_inc[TIDX_W-1:1]};
         right_in  = {1'b0, right_ff[TIDX_W-1:1]};
      end
      if (cmd.q_acc) begin
         acc_in = acc_ff + term_a + term_b;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         node_mem[waddr] <= wdata;
      end
      rda_ff <= node_mem[raddr_a];
      rdb_ff <= node_mem[raddr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff  <= '0;
         take_a_ff <= 1'b0;
         take_b_ff <= 1'b0;
      end else begin
         sweep_ff  <= sweep_in;
         take_a_ff <= take_a_in;
         take_b_ff <= take_b_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      acc_ff   <= acc_in;
   end

endmodule

// File: hdl/segment_tree_range_sum.sv
// Segment tree of signed sums over 1024 leaves, held in one 2048-entry memory with one
// write port and two read ports. A point write updates the leaf, then one tree level per
// cycle up to the root. A range query walks one level per cycle from the accepting edge
// to the result beat, with both range edges read in parallel.
// A clear, and the pass that follows reset, sweep the memory one node per cycle and hold
// busy high through the sweep. The result beat lasts exactly one cycle on rsp_valid and
// cannot be held off; busy is already low during that beat, so the next request can be
// taken on the same edge.
module segment_tree_range_sum (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [segtree_pkg::KIND_W-1:0]          req_type,
   input  logic [segtree_pkg::LEAF_W-1:0]          req_leaf_index,
   input  logic signed [segtree_pkg::VAL_W-1:0]    req_leaf_value,
   input  logic [segtree_pkg::NODE_AW-1:0]         req_range_left,
   input  logic [segtree_pkg::NODE_AW-1:0]         req_range_right,
   output logic                                    rsp_valid,
   output logic signed [segtree_pkg::NODE_W-1:0]   rsp_range_sum
);

   segtree_pkg::cmd_type              cmd;
   segtree_pkg::stat_type             stat;
   logic [segtree_pkg::NODE_W-1:0]    sum_out;

   segtree_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   segtree_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_leaf_index  (req_leaf_index),
      .req_leaf_value  (req_leaf_value),
      .req_range_left  (req_range_left),
      .req_range_right (req_range_right),
      .stat            (stat),
      .sum_out         (sum_out)
   );

   assign rsp_range_sum = sum_out;

endmodule

// File: hdl/segtree_checker.sv
module segtree_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [segtree_pkg::KIND_W-1:0]    req_type,
   input logic                              rsp_valid
);

   // The memory sweep after reset must keep new beats out.
   a_reset_sweep: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat longer than one cycle");

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy during a result beat");

   a_query_walk: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == segtree_pkg::REQ_QUERY) |=> busy && !rsp_valid)
      else $error("query did not start its tree walk");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == segtree_pkg::REQ_WRITE) |=> !rsp_valid ##1 !rsp_valid)
      else $error("point write produced a result beat");

endmodule

bind segment_tree_range_sum segtree_checker u_chk (.*);
